[design/hdep_pkg.sv]
// Shared types, constants and helper functions for the HTTP date to epoch parser.
package hdep_pkg;

    localparam int CH_W    = 8;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int POS_W   = 4;
    localparam int DCNT_W  = 3;
    localparam int EPOCH_W = 39;

    // Multiply-accumulate unit widths
    localparam int MAC_A_W = 24;
    localparam int MAC_B_W = 17;
    localparam int MAC_P_W = MAC_A_W + MAC_B_W + 1;
    localparam int ACC_W   = 40;
    localparam int SHIFT_W = 5;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CASE_GAP = 8'h20;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Field limits
    localparam int DAY_MAX  = 31;
    localparam int HOUR_MAX = 23;
    localparam int MIN_MAX  = 59;
    localparam int SEC_MAX  = 60;
    localparam int DAY_DIGITS  = 2;
    localparam int YEAR_DIGITS = 4;

    // Day-count constants. The year is offset by one era (400 years) so all
    // quotients work on non-negative values; the era's days come back out in
    // DAYS_BIAS together with the 1970 epoch offset and the day-of-month base.
    localparam int YEAR_ERA     = 400;
    localparam int DAYS_PER_ERA = 146097;
    localparam int EPOCH_DAYS   = 719468;
    localparam int DAYS_BIAS    = EPOCH_DAYS + DAYS_PER_ERA + 1;
    localparam int DAYS_PER_YR  = 365;
    localparam int SECS_PER_DAY = 86400;
    localparam int SECS_PER_HR  = 3600;
    localparam int SECS_PER_MIN = 60;

    // Reciprocals: floor(y / 100) = (y * RCP_100) >> SH_100, likewise /400,
    // exact for the year range after the era offset.
    localparam int RCP_100 = 10486;
    localparam int SH_100  = 20;
    localparam int RCP_400 = 5243;
    localparam int SH_400  = 21;
    localparam int SH_4    = 2;

    localparam logic [23:0] MONTH_NAMES [12] = '{
        "jan", "feb", "mar", "apr", "may", "jun",
        "jul", "aug", "sep", "oct", "nov", "dec"
    };

    typedef enum logic [3:0] {
        PH_PRE_DAY, PH_DAY, PH_PRE_MON, PH_MON1, PH_MON2, PH_PRE_YEAR,
        PH_YEAR, PH_PRE_HOUR, PH_H1, PH_HC, PH_M0, PH_M1, PH_MC, PH_S0,
        PH_S1, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ACC_NOP, ACC_ADD, ACC_SUB, ACC_LOAD
    } t_acc_op;

    typedef struct packed {
        t_acc_op             op;
        logic [SHIFT_W-1:0]  shift;
    } t_mac_cmd;

    typedef enum logic [1:0] {
        CV_IDLE, CV_RUN, CV_HOLD
    } t_conv_state;

    typedef enum logic [3:0] {
        CS_Y100, CS_Y400, CS_Y365, CS_Y4, CS_DRAIN,
        CS_DAY_SEC, CS_HOUR, CS_MIN, CS_SEC, CS_LAST
    } t_conv_step;

    typedef struct packed {
        logic                ok;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MIN_W-1:0]    minute;
        logic [SEC_W-1:0]    second;
    } t_date;

    function automatic logic [CH_W-1:0] fold_case(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        r = c;
        if (c inside {[CH_UP_A:CH_UP_Z]}) begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

    // Returns 1..12 for a matching name, 0 otherwise
    function automatic logic [MONTH_W-1:0] month_code(input logic [23:0] key);
        logic [MONTH_W-1:0] r;
        r = '0;
        for (int i = 0; i < 12; i++) begin
            if (r == '0 && key == MONTH_NAMES[i]) begin
                r = MONTH_W'(i + 1);
            end
        end
        return r;
    endfunction

    // Days from March 1 to the first of the month, year starting in March
    function automatic logic [8:0] month_base(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

[design/hdep_parser.sv]
// Character-at-a-time date grammar parser holding the parsed date fields.
module hdep_parser #(
    parameter int COMMA_WINDOW = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [hdep_pkg::CH_W-1:0]  i_ch,
    output hdep_pkg::t_date            o_date
);
    import hdep_pkg::*;

    t_phase              r_phase, n_phase;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_comma, n_comma;
    logic                r_failed, n_failed;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic [DAY_W-1:0]    r_day, n_day;
    logic [15:0]         r_mchars, n_mchars;
    logic [MONTH_W-1:0]  r_month, n_month;
    logic [YEAR_W-1:0]   r_year, n_year;
    logic [HOUR_W-1:0]   r_hour, n_hour;
    logic [MIN_W-1:0]    r_min, n_min;
    logic [SEC_W-1:0]    r_sec, n_sec;

    logic                dig;
    logic                sp;
    logic [3:0]          d;
    logic [CH_W-1:0]     fc;
    logic [8:0]          v_day;
    logic [YEAR_W-1:0]   v_year;
    logic [8:0]          v_hour;
    logic [9:0]          v_min;
    logic [9:0]          v_sec;
    logic [MONTH_W-1:0]  mcode;

    always_comb begin
        dig    = (i_ch inside {[CH_0:CH_9]});
        sp     = (i_ch == CH_SPACE);
        d      = dig ? 4'(i_ch - CH_0) : 4'd0;
        fc     = fold_case(i_ch);
        v_day  = 9'(r_day) * 9'd10 + 9'(d);
        v_year = r_year * YEAR_W'(10) + YEAR_W'(d);
        v_hour = 9'(r_hour) * 9'd10 + 9'(d);
        v_min  = 10'(r_min) * 10'd10 + 10'(d);
        v_sec  = 10'(r_sec) * 10'd10 + 10'(d);
        mcode  = month_code({r_mchars[7:0], r_mchars[15:8], fc});

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_comma  = r_comma;
        n_failed = r_failed;
        n_dcnt   = r_dcnt;
        n_day    = r_day;
        n_mchars = r_mchars;
        n_month  = r_month;
        n_year   = r_year;
        n_hour   = r_hour;
        n_min    = r_min;
        n_sec    = r_sec;

        if (i_valid) begin
            if (i_ch == CH_NUL || (i_ch == CH_COMMA && !r_comma
                    && r_pos < POS_W'(COMMA_WINDOW))) begin
                // terminator or first early comma: restart the parse
                n_phase  = PH_PRE_DAY;
                n_failed = 1'b0;
                n_dcnt   = '0;
                n_day    = '0;
                n_mchars = '0;
                n_month  = '0;
                n_year   = '0;
                n_hour   = '0;
                n_min    = '0;
                n_sec    = '0;
                n_comma  = (i_ch != CH_NUL);
            end else if (!r_failed) begin
                case (r_phase)
                    PH_PRE_DAY: begin
                        if (dig) begin
                            n_day   = DAY_W'(d);
                            n_dcnt  = DCNT_W'(1);
                            n_phase = PH_DAY;
                        end else if (!sp) begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_DAY: begin
                        if (dig) begin
                            if (r_dcnt >= DCNT_W'(DAY_DIGITS) || v_day > 9'(DAY_MAX)) begin
                                n_failed = 1'b1;
                            end else begin
                                n_day  = v_day[DAY_W-1:0];
                                n_dcnt = r_dcnt + 1'b1;
                            end
                        end else if (r_day == '0) begin
                            n_failed = 1'b1;
                        end else if (sp) begin
                            n_phase = PH_PRE_MON;
                        end else begin
                            n_mchars = {8'h00, fc};
                            n_phase  = PH_MON1;
                        end
                    end
                    PH_PRE_MON: begin
                        if (!sp) begin
                            n_mchars = {8'h00, fc};
                            n_phase  = PH_MON1;
                        end
                    end
                    PH_MON1: begin
                        n_mchars = {fc, r_mchars[7:0]};
                        n_phase  = PH_MON2;
                    end
                    PH_MON2: begin
                        if (mcode != '0) begin
                            n_month = mcode;
                            n_phase = PH_PRE_YEAR;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_PRE_YEAR: begin
                        if (dig) begin
                            n_year  = YEAR_W'(d);
                            n_dcnt  = DCNT_W'(1);
                            n_phase = PH_YEAR;
                        end else if (!sp) begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_YEAR: begin
                        if (dig) begin
                            if (r_dcnt >= DCNT_W'(YEAR_DIGITS)) begin
                                n_failed = 1'b1;
                            end else begin
                                n_year = v_year;
                                n_dcnt = r_dcnt + 1'b1;
                            end
                        end else if (sp && r_dcnt == DCNT_W'(YEAR_DIGITS)) begin
                            n_phase = PH_PRE_HOUR;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_PRE_HOUR: begin
                        if (dig) begin
                            n_hour  = HOUR_W'(d);
                            n_phase = PH_H1;
                        end else if (!sp) begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_H1: begin
                        if (!dig || v_hour > 9'(HOUR_MAX)) begin
                            n_failed = 1'b1;
                        end else begin
                            n_hour  = v_hour[HOUR_W-1:0];
                            n_phase = PH_HC;
                        end
                    end
                    PH_HC: begin
                        if (i_ch == CH_COLON) n_phase = PH_M0;
                        else n_failed = 1'b1;
                    end
                    PH_M0: begin
                        if (dig) begin
                            n_min   = MIN_W'(d);
                            n_phase = PH_M1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_M1: begin
                        if (!dig || v_min > 10'(MIN_MAX)) begin
                            n_failed = 1'b1;
                        end else begin
                            n_min   = v_min[MIN_W-1:0];
                            n_phase = PH_MC;
                        end
                    end
                    PH_MC: begin
                        if (i_ch == CH_COLON) n_phase = PH_S0;
                        else n_failed = 1'b1;
                    end
                    PH_S0: begin
                        if (dig) begin
                            n_sec   = SEC_W'(d);
                            n_phase = PH_S1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_S1: begin
                        if (!dig || v_sec > 10'(SEC_MAX)) begin
                            n_failed = 1'b1;
                        end else begin
                            n_sec   = v_sec[SEC_W-1:0];
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        // trailing text after the seconds: ignore
                    end
                endcase
            end

            if (i_ch == CH_NUL) begin
                n_pos = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PRE_DAY;
            r_pos    <= '0;
            r_comma  <= 1'b0;
            r_failed <= 1'b0;
            r_dcnt   <= '0;
            r_day    <= '0;
            r_mchars <= '0;
            r_month  <= '0;
            r_year   <= '0;
            r_hour   <= '0;
            r_min    <= '0;
            r_sec    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_comma  <= n_comma;
            r_failed <= n_failed;
            r_dcnt   <= n_dcnt;
            r_day    <= n_day;
            r_mchars <= n_mchars;
            r_month  <= n_month;
            r_year   <= n_year;
            r_hour   <= n_hour;
            r_min    <= n_min;
            r_sec    <= n_sec;
        end
    end

    assign o_date.ok     = !r_failed && (r_phase == PH_DONE);
    assign o_date.year   = r_year;
    assign o_date.month  = r_month;
    assign o_date.day    = r_day;
    assign o_date.hour   = r_hour;
    assign o_date.minute = r_min;
    assign o_date.second = r_sec;

endmodule

[design/hdep_mac.sv]
// Shared multiply then shift-accumulate unit used by the epoch conversion.
module hdep_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_init,
    input  logic signed [hdep_pkg::ACC_W-1:0]     i_init_val,
    input  hdep_pkg::t_mac_cmd                    i_cmd,
    input  logic signed [hdep_pkg::MAC_A_W-1:0]   i_a,
    input  logic [hdep_pkg::MAC_B_W-1:0]          i_b,
    output logic signed [hdep_pkg::ACC_W-1:0]     o_acc
);
    import hdep_pkg::*;

    t_mac_cmd                   r_cmd;
    logic signed [MAC_P_W-1:0]  r_p, n_p;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic signed [MAC_P_W-1:0]  p_shift;

    always_comb begin
        n_p     = i_a * $signed({1'b0, i_b});
        p_shift = r_p >>> r_cmd.shift;
        n_acc   = r_acc;
        if (i_init) begin
            n_acc = i_init_val;
        end else begin
            case (r_cmd.op)
                ACC_ADD:  n_acc = r_acc + ACC_W'(p_shift);
                ACC_SUB:  n_acc = r_acc - ACC_W'(p_shift);
                ACC_LOAD: n_acc = ACC_W'(p_shift);
                default:  n_acc = r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= '{op: ACC_NOP, shift: '0};
        end else begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

[design/hdep_conv.sv]
// Sequencer that turns a parsed date into epoch seconds on the shared MAC unit.
module hdep_conv (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  hdep_pkg::t_date                      i_date,
    output logic                                 o_busy,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output logic                                 o_res_ok,
    output logic [hdep_pkg::EPOCH_W-1:0]         o_res_epoch
);
    import hdep_pkg::*;

    t_conv_state          r_state, n_state;
    t_conv_step           r_step, n_step;
    logic                 r_ok;
    logic [YEAR_W-1:0]    r_yoff;
    logic [HOUR_W-1:0]    r_hour;
    logic [MIN_W-1:0]     r_min;
    logic [SEC_W-1:0]     r_sec;

    logic                 mac_init;
    logic signed [ACC_W-1:0]   init_val;
    t_mac_cmd             cmd;
    logic signed [MAC_A_W-1:0] op_a;
    logic [MAC_B_W-1:0]   op_b;
    logic signed [ACC_W-1:0]   acc;
    logic [YEAR_W-1:0]    yoff;

    // March-based year, shifted up one era
    assign yoff = i_date.year + YEAR_W'(YEAR_ERA)
                - ((i_date.month < MONTH_W'(3)) ? YEAR_W'(1) : YEAR_W'(0));
    assign init_val = ACC_W'(month_base(i_date.month)) + ACC_W'(i_date.day)
                    - ACC_W'(DAYS_BIAS);

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        mac_init = 1'b0;
        cmd      = '{op: ACC_NOP, shift: '0};
        op_a     = MAC_A_W'(r_yoff);
        op_b     = '0;
        case (r_state)
            CV_IDLE: begin
                if (i_start) begin
                    mac_init = 1'b1;
                    n_step   = CS_Y100;
                    n_state  = i_date.ok ? CV_RUN : CV_HOLD;
                end
            end
            CV_RUN: begin
                n_step = t_conv_step'(r_step + 1'b1);
                case (r_step)
                    CS_Y100: begin
                        op_b = MAC_B_W'(RCP_100);
                        cmd  = '{op: ACC_SUB, shift: SHIFT_W'(SH_100)};
                    end
                    CS_Y400: begin
                        op_b = MAC_B_W'(RCP_400);
                        cmd  = '{op: ACC_ADD, shift: SHIFT_W'(SH_400)};
                    end
                    CS_Y365: begin
                        op_b = MAC_B_W'(DAYS_PER_YR);
                        cmd  = '{op: ACC_ADD, shift: '0};
                    end
                    CS_Y4: begin
                        op_b = MAC_B_W'(1);
                        cmd  = '{op: ACC_ADD, shift: SHIFT_W'(SH_4)};
                    end
                    CS_DAY_SEC: begin
                        // day count is complete in the accumulator now
                        op_a = acc[MAC_A_W-1:0];
                        op_b = MAC_B_W'(SECS_PER_DAY);
                        cmd  = '{op: ACC_LOAD, shift: '0};
                    end
                    CS_HOUR: begin
                        op_a = MAC_A_W'(r_hour);
                        op_b = MAC_B_W'(SECS_PER_HR);
                        cmd  = '{op: ACC_ADD, shift: '0};
                    end
                    CS_MIN: begin
                        op_a = MAC_A_W'(r_min);
                        op_b = MAC_B_W'(SECS_PER_MIN);
                        cmd  = '{op: ACC_ADD, shift: '0};
                    end
                    CS_SEC: begin
                        op_a = MAC_A_W'(r_sec);
                        op_b = MAC_B_W'(1);
                        cmd  = '{op: ACC_ADD, shift: '0};
                    end
                    CS_LAST: begin
                        n_state = CV_HOLD;
                    end
                    default: begin
                        // drain cycle: let the last product land
                    end
                endcase
            end
            CV_HOLD: begin
                if (i_res_ready) n_state = CV_IDLE;
            end
            default: n_state = CV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CV_IDLE;
            r_step  <= CS_Y100;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == CV_IDLE && i_start) begin
            r_ok   <= i_date.ok;
            r_yoff <= yoff;
            r_hour <= i_date.hour;
            r_min  <= i_date.minute;
            r_sec  <= i_date.second;
        end
    end

    hdep_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (mac_init),
        .i_init_val (init_val),
        .i_cmd      (cmd),
        .i_a        (op_a),
        .i_b        (op_b),
        .o_acc      (acc)
    );

    assign o_busy      = (r_state != CV_IDLE);
    assign o_res_valid = (r_state == CV_HOLD);
    assign o_res_ok    = r_ok;
    assign o_res_epoch = r_ok ? acc[EPOCH_W-1:0] : '0;

endmodule

[design/http_date_to_epoch_parser_unit.sv]
// Top level: date string parser with epoch-seconds conversion and output register.
//
//  channel  | dir | signals                                 | word
//  ---------+-----+-----------------------------------------+--------------------------------
//  s (char) | in  | i_s_tvalid, o_s_tready, i_s_tdata       | one character, NUL ends string
//  m (res)  | out | o_m_tvalid, i_m_tready, o_m_tdata, tuser| ok flag and epoch seconds
//
// Ordinary characters are taken one per cycle while the sequencer is idle. A NUL word
// hands the parsed fields to the conversion sequencer, which runs ten steps on one
// shared multiply-accumulate unit; a string that failed to parse skips them.
// o_s_tready stays low after a NUL word until the result moves into the output
// register, and that move waits while the output register is still full.
// Reset (i_rst_n low, synchronous) returns the parser to the start of a
// string and empties the sequencer and output register.
// A result waiting in the output register stalls character input once the sequencer holds the next result.
module http_date_to_epoch_parser_unit #(
    parameter int COMMA_WINDOW = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch

    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [38:0] epoch_seconds, [39] zero fill
    output logic        o_m_tuser    // [0] ok
);
    import hdep_pkg::*;

    logic                s_accept;
    logic                start;
    t_date               date;
    logic                conv_busy;
    logic                res_valid;
    logic                res_take;
    logic                res_ok;
    logic [EPOCH_W-1:0]  res_epoch;

    logic                r_out_valid;
    logic                r_out_ok;
    logic [EPOCH_W-1:0]  r_out_epoch;

    // Take characters whenever the sequencer is free
    assign o_s_tready = !conv_busy;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign start      = s_accept && (i_s_tdata == CH_NUL);

    hdep_parser #(
        .COMMA_WINDOW (COMMA_WINDOW)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_accept),
        .i_ch    (i_s_tdata),
        .o_date  (date)
    );

    hdep_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_date      (date),
        .o_busy      (conv_busy),
        .o_res_valid (res_valid),
        .i_res_ready (res_take),
        .o_res_ok    (res_ok),
        .o_res_epoch (res_epoch)
    );

    // Advance the result into the output register when it is empty or draining
    assign res_take = res_valid && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_ok    <= res_ok;
            r_out_epoch <= res_epoch;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_epoch};
    assign o_m_tuser  = r_out_ok;

endmodule
